[rtl/core/run_length_byte_encoder_top_assert.svh]
// Assertion macros used by the run-length byte encoder checker.
`ifndef RUN_LENGTH_BYTE_ENCODER_TOP_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define RLBE_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rlbe checker: same-cycle implication failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define RLBE_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rlbe checker: next-cycle implication failed");

`endif

[rtl/core/rlbe_pkg.sv]
// Package of types, constants and command codes for the run-length byte encoder.
`default_nettype none

package rlbe_pkg;

	// Longest repeat or literal block, and bytes packed into one output word.
	localparam int MAX_RUN        = 128;
	localparam int BYTES_PER_WORD = 8;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 64;
	localparam int VB_W   = 4;
	localparam int LIT_AW = $clog2(MAX_RUN);
	localparam int CNT_W  = $clog2(MAX_RUN + 1);
	localparam int FILL_W = $clog2(BYTES_PER_WORD);

	// Repeat blocks open at three equal bytes; their flag byte is 257 minus the count.
	localparam int REP_START_COUNT = 3;
	localparam int REP_FLAG_BASE   = 257;

	// Request carried by the byte channel.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              final_byte;
	} in_item_t;

	// Request carried by the word channel.
	typedef struct packed {
		logic [WORD_W-1:0] packed_word;
		logic [VB_W-1:0]   valid_bytes;
		logic              stream_end;
	} out_item_t;

	// Lookahead register operations.
	typedef enum logic [2:0] {
		LA_NONE,
		LA_LOAD_X,
		LA_PAIR,
		LA_SHIFT,
		LA_CLEAR
	} la_op_t;

	// Repeat run register operations.
	typedef enum logic [1:0] {
		REP_NONE,
		REP_INC,
		REP_START,
		REP_END
	} rep_op_t;

	// Source of the byte handed to the word assembler.
	typedef enum logic [1:0] {
		BYTE_LIT_FLAG,
		BYTE_LIT_DATA,
		BYTE_REP_FLAG,
		BYTE_REP_VAL
	} byte_sel_t;

	// Source of a byte written into the literal store.
	typedef enum logic {
		SRC_LA,
		SRC_X
	} lit_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_in;
		la_op_t    la_op;
		rep_op_t   rep_op;
		logic      lit_add;
		lit_src_t  lit_src;
		logic      lit_done;
		logic      rd_start;
		logic      rd_next;
		logic      put;
		byte_sel_t byte_sel;
		logic      put_last;
		logic      clear_all;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       fin;
		logic       x_eq_a;
		logic       x_eq_rv;
		logic       rc_lt_max;
		logic       rep_mode;
		logic [1:0] la_fill;
		logic       lc_zero;
		logic       lc_is_last;
		logic       idx_is_last;
		logic       put_ready;
	} dp_status_t;

endpackage

`default_nettype wire

[rtl/core/rlbe_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rlbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, and a read port whose data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rlbe_datapath.sv]
// Datapath of the run-length byte encoder: lookahead, run and literal state, word assembly.
`default_nettype none

module rlbe_datapath import rlbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  in_item_t   byte_item,
	output logic       word_valid,
	input  logic       word_ready,
	output out_item_t  word_item
);

	logic [BYTE_W-1:0] x_q;
	logic              fin_q;
	logic [BYTE_W-1:0] la0_q;
	logic [BYTE_W-1:0] la1_q;
	logic [1:0]        la_fill_q;
	logic              rep_mode_q;
	logic [BYTE_W-1:0] rv_q;
	logic [CNT_W-1:0]  rc_q;
	logic [CNT_W-1:0]  lc_q;
	logic [LIT_AW-1:0] idx_q;
	logic [WORD_W-1:0] asm_word_q;
	logic [FILL_W-1:0] asm_fill_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic [BYTE_W-1:0] lit_wdata;
	logic [LIT_AW-1:0] ram_raddr;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] put_byte;
	logic [WORD_W-1:0] asm_next;
	logic              word_end;
	logic              out_free;
	logic              put_ready;
	logic              put_fire;
	logic              word_done;

	// Literal store: written at the literal count, drained from entry zero upwards.
	assign lit_wdata = (cmd.lit_src == SRC_X) ? x_q : la0_q;
	assign ram_re    = cmd.rd_start | cmd.rd_next;
	assign ram_raddr = cmd.rd_start ? '0 : idx_q + LIT_AW'(1);

	rlbe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_RUN)
	) u_lit_ram (
		.clk   (clk),
		.we    (cmd.lit_add),
		.waddr (lc_q[LIT_AW-1:0]),
		.wdata (lit_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Choice of the next encoded byte.
	always_comb begin
		unique case (cmd.byte_sel)
			BYTE_LIT_FLAG: put_byte = BYTE_W'(lc_q - CNT_W'(1));
			BYTE_LIT_DATA: put_byte = ram_rdata;
			BYTE_REP_FLAG: put_byte = BYTE_W'(REP_FLAG_BASE - int'(rc_q));
			BYTE_REP_VAL:  put_byte = rv_q;
		endcase
	end

	// The byte goes into the lane that the fill count points at.
	always_comb begin
		asm_next = asm_word_q;
		for (int i = 0; i < BYTES_PER_WORD; i++) begin
			if (asm_fill_q == FILL_W'(i)) begin
				asm_next[i*BYTE_W +: BYTE_W] = put_byte;
			end
		end
	end

	// A byte is taken unless it completes a word while the output register is still full.
	assign word_end  = (asm_fill_q == FILL_W'(BYTES_PER_WORD - 1)) | cmd.put_last;
	assign out_free  = !out_valid_q | word_ready;
	assign put_ready = out_free | !word_end;
	assign put_fire  = cmd.put & put_ready;
	assign word_done = put_fire & word_end;

	// Input byte latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (cmd.load_in) begin
			fin_q <= byte_item.final_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= byte_item.data_byte;
		end
	end

	// Lookahead pair and its fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_fill_q <= 2'd0;
		end else if (cmd.clear_all) begin
			la_fill_q <= 2'd0;
		end else begin
			unique case (cmd.la_op)
				LA_NONE:   la_fill_q <= la_fill_q;
				LA_LOAD_X: la_fill_q <= 2'd1;
				LA_PAIR:   la_fill_q <= 2'd2;
				LA_SHIFT:  la_fill_q <= la_fill_q - 2'd1;
				LA_CLEAR:  la_fill_q <= 2'd0;
				default:   la_fill_q <= la_fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.la_op)
			LA_LOAD_X: la0_q <= x_q;
			LA_PAIR:   la1_q <= x_q;
			LA_SHIFT:  la0_q <= la1_q;
			default: begin
			end
		endcase
	end

	// Repeat run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_mode_q <= 1'b0;
			rv_q       <= '0;
			rc_q       <= '0;
		end else if (cmd.clear_all) begin
			rep_mode_q <= 1'b0;
			rv_q       <= '0;
			rc_q       <= '0;
		end else begin
			unique case (cmd.rep_op)
				REP_NONE: begin
				end
				REP_INC: begin
					rc_q <= rc_q + CNT_W'(1);
				end
				REP_START: begin
					rep_mode_q <= 1'b1;
					rv_q       <= la0_q;
					rc_q       <= CNT_W'(REP_START_COUNT);
				end
				REP_END: begin
					rep_mode_q <= 1'b0;
					rc_q       <= '0;
				end
			endcase
		end
	end

	// Literal count and drain index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q  <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.clear_all || cmd.lit_done) begin
				lc_q <= '0;
			end else if (cmd.lit_add) begin
				lc_q <= lc_q + CNT_W'(1);
			end
			if (cmd.rd_start) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_q + LIT_AW'(1);
			end
		end
	end

	// Word assembly and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_word_q  <= '0;
			asm_fill_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (word_done) begin
				asm_word_q  <= '0;
				asm_fill_q  <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (put_fire) begin
					asm_word_q <= asm_next;
					asm_fill_q <= asm_fill_q + FILL_W'(1);
				end
				if (word_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_done) begin
			out_item_q.packed_word <= asm_next;
			out_item_q.valid_bytes <= VB_W'(asm_fill_q) + VB_W'(1);
			out_item_q.stream_end  <= cmd.put_last;
		end
	end

	assign word_valid = out_valid_q;
	assign word_item  = out_item_q;

	// Status towards the controller.
	assign status.fin         = fin_q;
	assign status.x_eq_a      = (x_q == la0_q);
	assign status.x_eq_rv     = (x_q == rv_q);
	assign status.rc_lt_max   = (rc_q < CNT_W'(MAX_RUN));
	assign status.rep_mode    = rep_mode_q;
	assign status.la_fill     = la_fill_q;
	assign status.lc_zero     = (lc_q == '0);
	assign status.lc_is_last  = (lc_q == CNT_W'(MAX_RUN - 1));
	assign status.idx_is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == lc_q);
	assign status.put_ready   = put_ready;

endmodule

`default_nettype wire

[rtl/core/rlbe_ctrl.sv]
// Controller state machine of the run-length byte encoder.
`default_nettype none

module rlbe_ctrl import rlbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_LIT_FLAG,
		S_LIT_DATA,
		S_REP_FLAG,
		S_REP_VAL
	} state_t;

	state_t state_q, state_d;
	logic   x_done_q, x_done_d;
	logic   rep_final_q, rep_final_d;
	logic   lit_final;

	// A literal block closed after the final byte has joined it ends the stream.
	assign lit_final  = status.fin & x_done_q;
	assign byte_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		x_done_d    = x_done_q;
		rep_final_d = rep_final_q;
		unique case (state_q)
			S_IDLE: begin
				if (byte_valid) begin
					cmd.load_in = 1'b1;
					x_done_d    = 1'b0;
					rep_final_d = 1'b0;
					state_d     = S_STEP;
				end
			end
			S_STEP: begin
				if (x_done_q) begin
					// Byte handled: close what is left at the end of the data.
					if (status.fin && !status.lc_zero) begin
						state_d = S_LIT_FLAG;
					end else begin
						cmd.clear_all = status.fin;
						state_d       = S_IDLE;
					end
				end else if (status.rep_mode) begin
					// Extend the run, or close it and look at the byte afresh.
					if (status.x_eq_rv && status.rc_lt_max) begin
						cmd.rep_op = REP_INC;
						x_done_d   = 1'b1;
						if (status.fin) begin
							rep_final_d = 1'b1;
							state_d     = S_REP_FLAG;
						end else begin
							state_d = S_IDLE;
						end
					end else begin
						state_d = S_REP_FLAG;
					end
				end else if (status.fin) begin
					// Final byte: three equal bytes make a run, anything else goes literal.
					if (status.la_fill == 2'd2 && status.x_eq_a) begin
						if (!status.lc_zero) begin
							state_d = S_LIT_FLAG;
						end else begin
							cmd.rep_op  = REP_START;
							cmd.la_op   = LA_CLEAR;
							x_done_d    = 1'b1;
							rep_final_d = 1'b1;
							state_d     = S_REP_FLAG;
						end
					end else if (status.la_fill != 2'd0) begin
						cmd.lit_add = 1'b1;
						cmd.lit_src = SRC_LA;
						cmd.la_op   = LA_SHIFT;
						state_d     = status.lc_is_last ? S_LIT_FLAG : S_STEP;
					end else begin
						cmd.lit_add = 1'b1;
						cmd.lit_src = SRC_X;
						x_done_d    = 1'b1;
						state_d     = status.lc_is_last ? S_LIT_FLAG : S_STEP;
					end
				end else begin
					// Ordinary byte against the lookahead pair.
					priority if (status.la_fill == 2'd0) begin
						cmd.la_op = LA_LOAD_X;
						x_done_d  = 1'b1;
						state_d   = S_IDLE;
					end else if (status.la_fill == 2'd1) begin
						if (status.x_eq_a) begin
							cmd.la_op = LA_PAIR;
							x_done_d  = 1'b1;
							state_d   = S_IDLE;
						end else begin
							cmd.lit_add = 1'b1;
							cmd.lit_src = SRC_LA;
							cmd.la_op   = LA_LOAD_X;
							x_done_d    = 1'b1;
							state_d     = status.lc_is_last ? S_LIT_FLAG : S_IDLE;
						end
					end else begin
						if (status.x_eq_a) begin
							if (!status.lc_zero) begin
								state_d = S_LIT_FLAG;
							end else begin
								cmd.rep_op = REP_START;
								cmd.la_op  = LA_CLEAR;
								x_done_d   = 1'b1;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.lit_add = 1'b1;
							cmd.lit_src = SRC_LA;
							cmd.la_op   = LA_SHIFT;
							state_d     = status.lc_is_last ? S_LIT_FLAG : S_STEP;
						end
					end
				end
			end
			S_LIT_FLAG: begin
				cmd.put      = 1'b1;
				cmd.byte_sel = BYTE_LIT_FLAG;
				if (status.put_ready) begin
					cmd.rd_start = 1'b1;
					state_d      = S_LIT_DATA;
				end
			end
			S_LIT_DATA: begin
				cmd.put      = 1'b1;
				cmd.byte_sel = BYTE_LIT_DATA;
				cmd.put_last = lit_final & status.idx_is_last;
				if (status.put_ready) begin
					if (status.idx_is_last) begin
						cmd.lit_done = 1'b1;
						state_d      = S_STEP;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			S_REP_FLAG: begin
				cmd.put      = 1'b1;
				cmd.byte_sel = BYTE_REP_FLAG;
				if (status.put_ready) begin
					state_d = S_REP_VAL;
				end
			end
			S_REP_VAL: begin
				cmd.put      = 1'b1;
				cmd.byte_sel = BYTE_REP_VAL;
				cmd.put_last = rep_final_q;
				if (status.put_ready) begin
					cmd.rep_op = REP_END;
					state_d    = S_STEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_done_q    <= 1'b0;
			rep_final_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			x_done_q    <= x_done_d;
			rep_final_q <= rep_final_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/run_length_byte_encoder_top.sv]
// Top level of the run-length byte encoder: controller and datapath.
//
// Channel  Role    Handshake                 Request
// byte     input   byte_valid / byte_ready   in_item_t: data_byte, final_byte
// word     output  word_valid / word_ready   out_item_t: packed_word, valid_bytes, stream_end
//
// One byte is taken at a time. A byte that emits nothing is accepted in S_IDLE and decided
// in S_STEP. Each encoded byte is put out by the state machine, which writes one byte a cycle
// into the word assembler while it is ready; closing a literal block puts out its flag byte
// and then its stored bytes, paced by the single read port of the literal store.
// A completed word waits in the output register; the encoder stalls only when the next
// word is complete before that register has been emptied.
// Reset clears all control state and the assembly word; the literal store needs no clearing.
`default_nettype none

module run_length_byte_encoder_top import rlbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_item_t  byte_item,
	output logic      word_valid,
	input  logic      word_ready,
	output out_item_t word_item
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing of block decisions and byte emission.
	rlbe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.cmd        (cmd),
		.status     (status)
	);

	// Encoding state, literal store and word packing.
	rlbe_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.byte_item  (byte_item),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_item  (word_item)
	);

endmodule

`default_nettype wire

[rtl/core/rlbe_checker.sv]
// Port-level checker for the run-length byte encoder, bound to its top level.
`default_nettype none

`include "run_length_byte_encoder_top_assert.svh"

module rlbe_checker import rlbe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      byte_valid,
	input logic      byte_ready,
	input in_item_t  byte_item,
	input logic      word_valid,
	input logic      word_ready,
	input out_item_t word_item
);

	logic vb_in_range;
	logic vb_full;

	// Byte counts of the word on offer.
	assign vb_in_range = (word_item.valid_bytes != 4'd0) &&
		(word_item.valid_bytes <= 4'(BYTES_PER_WORD));
	assign vb_full     = (word_item.valid_bytes == 4'(BYTES_PER_WORD));

	// A stalled word request holds still.
	`RLBE_ASSERT_NXT(a_word_hold, word_valid && !word_ready, word_valid && $stable(word_item))

	// Every word carries between one and a full word of bytes.
	`RLBE_ASSERT_IMP(a_bytes_range, word_valid, vb_in_range)

	// Only the last word of a stream may be short.
	`RLBE_ASSERT_IMP(a_full_words, word_valid && !word_item.stream_end, vb_full)

	// Bytes are taken one at a time, never in consecutive cycles.
	`RLBE_ASSERT_NXT(a_one_byte, byte_valid && byte_ready, !byte_ready)

endmodule

bind run_length_byte_encoder_top rlbe_checker u_rlbe_checker (.*);

`default_nettype wire

[test/run_length_byte_encoder_top_tb.sv]
// Self-checking testbench for the run-length byte encoder: byte streams in, packed words checked.
module run_length_byte_encoder_top_tb import rlbe_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int TARGET_BYTES = 500;
	localparam int HOLD_AFTER   = 350;
	localparam int HOLD_CYCLES  = 500;

	// Receiver behaviour modes for word_ready.
	typedef enum int {
		READY_ALWAYS,
		READY_RANDOM,
		READY_SPARSE,
		READY_MOSTLY
	} stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_ready;
	in_item_t  byte_item = '0;
	logic      word_valid;
	logic      word_ready = 1'b0;
	out_item_t word_item;

	in_item_t  pending_bytes[$];
	out_item_t expected_words[$];
	int        mismatches = 0;
	int        requests_taken = 0;
	int        idle_cycles = 0;

	// Encoder state as seen by the predictor.
	logic [7:0]  lit_buf [128];
	int          lit_len = 0;
	logic [15:0] la_pair = '0;
	int          la_fill = 0;
	bit          in_run = 1'b0;
	logic [7:0]  run_val = '0;
	int          run_len = 0;
	logic [63:0] asm_word = '0;
	int          asm_fill = 0;

	run_length_byte_encoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word_item (word_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Append one encoded byte to the word under assembly; a full word becomes an expectation.
	task automatic pack_byte(input logic [7:0] b);
		out_item_t w;
		asm_word[8*asm_fill +: 8] = b;
		asm_fill++;
		if (asm_fill >= BYTES_PER_WORD) begin
			w.packed_word = asm_word;
			w.valid_bytes = VB_W'(asm_fill);
			w.stream_end  = 1'b0;
			expected_words.push_back(w);
			asm_word = '0;
			asm_fill = 0;
		end
	endtask

	// Emit the open literal block, if any: its flag byte and then the stored bytes.
	task automatic flush_literal();
		if (lit_len == 0)
			return;
		pack_byte(8'(lit_len - 1));
		for (int i = 0; i < lit_len; i++)
			pack_byte(lit_buf[i]);
		lit_len = 0;
	endtask

	task automatic append_literal(input logic [7:0] b);
		lit_buf[lit_len] = b;
		lit_len++;
		if (lit_len >= MAX_RUN)
			flush_literal();
	endtask

	task automatic flush_run();
		pack_byte(8'(REP_FLAG_BASE - run_len));
		pack_byte(run_val);
		in_run  = 1'b0;
		run_len = 0;
	endtask

	// Feed one byte that is not the last of its stream.
	task automatic encode_byte(input logic [7:0] x);
		logic [7:0] a;
		if (in_run) begin
			if (x == run_val && run_len < MAX_RUN) begin
				run_len++;
				return;
			end
			flush_run();
		end
		a = la_pair[7:0];
		if (la_fill == 0) begin
			la_pair = {8'h00, x};
			la_fill = 1;
		end else if (la_fill == 1) begin
			if (a != x) begin
				append_literal(a);
				la_pair = {8'h00, x};
			end else begin
				la_pair = {x, a};
				la_fill = 2;
			end
		end else if (x == a) begin
			// Third equal byte: the literal block closes and a run opens.
			flush_literal();
			in_run  = 1'b1;
			run_val = a;
			run_len = REP_START_COUNT;
			la_pair = '0;
			la_fill = 0;
		end else begin
			append_literal(a);
			append_literal(la_pair[15:8]);
			la_pair = {8'h00, x};
			la_fill = 1;
		end
	endtask

	// Feed the last byte of a stream: close every open block and flush the partial word.
	task automatic encode_last_byte(input logic [7:0] x);
		logic [7:0] a;
		logic [7:0] b;
		out_item_t  w;
		a = la_pair[7:0];
		b = la_pair[15:8];
		if (in_run) begin
			if (x == run_val && run_len < MAX_RUN) begin
				run_len++;
				flush_run();
			end else begin
				flush_run();
				append_literal(x);
			end
		end else if (la_fill >= 2 && a == b && b == x) begin
			flush_literal();
			run_val = a;
			run_len = REP_START_COUNT;
			flush_run();
		end else begin
			if (la_fill >= 1)
				append_literal(a);
			if (la_fill >= 2)
				append_literal(b);
			append_literal(x);
		end
		flush_literal();
		// The final byte always emits something, so a word exists to carry the end mark.
		if (asm_fill > 0) begin
			w.packed_word = asm_word;
			w.valid_bytes = VB_W'(asm_fill);
			w.stream_end  = 1'b1;
			expected_words.push_back(w);
		end else begin
			w = expected_words.pop_back();
			w.stream_end = 1'b1;
			expected_words.push_back(w);
		end
		asm_word = '0;
		asm_fill = 0;
		la_pair  = '0;
		la_fill  = 0;
		in_run   = 1'b0;
		run_val  = '0;
		run_len  = 0;
	endtask

	task automatic encode_request(input in_item_t r);
		if (r.final_byte)
			encode_last_byte(r.data_byte);
		else
			encode_byte(r.data_byte);
	endtask

	task automatic queue_stream(input logic [7:0] bytes[$]);
		in_item_t r;
		foreach (bytes[i]) begin
			r.data_byte  = bytes[i];
			r.final_byte = (i == bytes.size() - 1);
			pending_bytes.push_back(r);
		end
	endtask

	// A stream built from runs and mixed stretches; long blocks only when asked for.
	task automatic build_stream(input bit with_long_blocks);
		logic [7:0] bytes[$];
		logic [7:0] v;
		int         segs;
		int         len;
		bit         narrow;
		if (with_long_blocks) begin
			v   = 8'($urandom_range(0, 255));
			len = $urandom_range(128, 131);
			repeat (len) bytes.push_back(v);
			// Successive bytes differ, so this stays one literal block until it is full.
			len = $urandom_range(127, 130);
			repeat (len) begin
				v = v + 8'($urandom_range(1, 255));
				bytes.push_back(v);
			end
		end
		segs = $urandom_range(1, 6);
		repeat (segs) begin
			if ($urandom_range(0, 1) == 0) begin
				v   = 8'($urandom_range(0, 255));
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				repeat (len) bytes.push_back(v);
			end else begin
				narrow = $urandom_range(0, 1);
				len    = $urandom_range(1, 10);
				repeat (len)
					bytes.push_back(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
			end
		end
		queue_stream(bytes);
	endtask

	// Sender: bursts of requests separated by random gaps.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && byte_ready) begin
				encode_request(byte_item);
				requests_taken <= requests_taken + 1;
			end
			if (!byte_valid || byte_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					byte_item  <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each word with the oldest expectation and pace word_ready.
	stall_mode_t stall_mode = READY_ALWAYS;
	int          pattern_left = 0;
	int          phase = 0;
	int          holdoff_left = 0;
	bit          holdoff_done = 1'b0;

	task automatic check_word(input out_item_t got);
		out_item_t want;
		if (expected_words.size() == 0) begin
			$error("word with no expectation waiting: packed_word %h", got.packed_word);
			mismatches++;
			return;
		end
		want = expected_words.pop_front();
		if (got.packed_word !== want.packed_word) begin
			$error("packed_word: expected %h, actual %h", want.packed_word, got.packed_word);
			mismatches++;
		end
		if (got.valid_bytes !== want.valid_bytes) begin
			$error("valid_bytes: expected %0d, actual %0d", want.valid_bytes, got.valid_bytes);
			mismatches++;
		end
		if (got.stream_end !== want.stream_end) begin
			$error("stream_end: expected %0b, actual %0b", want.stream_end, got.stream_end);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			word_ready <= 1'b0;
		end else begin
			if (word_valid && word_ready)
				check_word(word_item);
			// One long hold-off so that the encoder backs up and refuses bytes.
			if (!holdoff_done && requests_taken >= HOLD_AFTER) begin
				holdoff_left = HOLD_CYCLES;
				holdoff_done = 1'b1;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				word_ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					stall_mode   = stall_mode_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(16, 96);
				end
				pattern_left--;
				phase++;
				case (stall_mode)
					READY_ALWAYS: word_ready <= 1'b1;
					READY_RANDOM: word_ready <= 1'($urandom_range(0, 1));
					READY_SPARSE: word_ready <= (phase % 4 == 0);
					default:      word_ready <= (phase % 4 != 0);
				endcase
			end
		end
	end

	// Cycles in which neither channel moved a request.
	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (word_valid && word_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		// Single byte, a run of three at the end, two differing bytes.
		queue_stream('{8'h00});
		queue_stream('{8'hFF, 8'hFF, 8'hFF});
		queue_stream('{8'h12, 8'h34});
		// A pair that breaks at the end, and a run followed by literals.
		queue_stream('{8'hAA, 8'hAA, 8'h55});
		queue_stream('{8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h01, 8'h80});
		queue_stream('{8'h01, 8'h01});
		// A run still open when a different last byte arrives.
		queue_stream('{8'h5A, 8'h5A, 8'h5A, 8'hA5});
		queue_stream('{8'h3C, 8'hC3, 8'h3C, 8'hC3});
		build_stream(1'b1);
		while (pending_bytes.size() < TARGET_BYTES)
			build_stream(1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || byte_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rlbe_pkg.sv
rtl/core/rlbe_ram.sv
rtl/core/rlbe_datapath.sv
rtl/core/rlbe_ctrl.sv
rtl/core/run_length_byte_encoder_top.sv
rtl/core/rlbe_checker.sv
test/run_length_byte_encoder_top_tb.sv
